[design/su2q_pkg.sv]
// package with the operation codes of the su2 quaternion unit
`timescale 1ns / 1ps

package su2q_pkg;

    localparam int unsigned MODE_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_PRODUCT = 3'd0,
        MODE_SUM     = 3'd1,
        MODE_DIFF    = 3'd2,
        MODE_DAGGER  = 3'd3,
        MODE_TRACE   = 3'd4,
        MODE_DET     = 3'd5
    } t_mode;

    // register stages from input capture up to and including the output register
    localparam int unsigned PIPE_DEPTH = 4;

endpackage

[design/su2_quaternion_alu.sv]
// su2 quaternion arithmetic unit: product, sum, difference, dagger, trace, determinant
`timescale 1ns / 1ps

// Four register stages: input capture, sixteen parallel signed multipliers with
// the fractional shift, the four-term sums and mode selection, then saturation
// into the output register. One transaction is taken every cycle while tready is
// high; an accepted input moves through the product and sum registers into the
// output register. A stall on the output fills empty stages first, so tready on
// the input only drops once every stage holds an item. While the output is not
// stalled, every stage passes its item on each cycle, which sets the rate of one
// transaction per cycle; the multiplier stage, which forms all sixteen component
// products at once, is the deepest stage.
module su2_quaternion_alu #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // a0, a1, a2, a3, b0, b1, b2, b3
    input  logic [8*DATA_WIDTH-1:0]       i_s_axis_tdata,
    // mode
    input  logic [su2q_pkg::MODE_W-1:0]   i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // r0, r1, r2, r3, zero padding to whole bytes
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int W     = DATA_WIDTH;
    localparam int PW    = 2 * DATA_WIDTH;
    localparam int LIN_W = DATA_WIDTH + 2;
    localparam int ACC_W = 2 * DATA_WIDTH + 2;

    localparam logic signed [ACC_W-1:0] MAX_V = {{(ACC_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] MIN_V = {{(ACC_W-W+1){1'b1}}, {(W-1){1'b0}}};

    // stage 1: captured operands
    logic                   r_v1;
    su2q_pkg::t_mode        r_mode1;
    logic signed [W-1:0]    r_a1 [4];
    logic signed [W-1:0]    r_b1 [4];

    // stage 2: shifted products and linear results
    logic                   r_v2;
    su2q_pkg::t_mode        r_mode2;
    logic signed [PW-1:0]   r_prod2 [4][4];
    logic signed [LIN_W-1:0] r_lin2 [4];
    logic signed [PW-1:0]   n_prod2 [4][4];
    logic signed [LIN_W-1:0] n_lin2 [4];

    // stage 3: exact results
    logic                   r_v3;
    logic signed [ACC_W-1:0] r_acc3 [4];
    logic signed [ACC_W-1:0] n_acc3 [4];

    // stage 4: saturated output
    logic                   r_v4;
    logic signed [W-1:0]    r_res4 [4];
    logic signed [W-1:0]    n_res4 [4];

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4 = !r_v4 || i_m_axis_tready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign o_s_axis_tready = w_rdy1;
    assign o_m_axis_tvalid = r_v4;

    always_comb begin
        o_m_axis_tdata = '0;
        for (int i = 0; i < 4; i++) begin
            o_m_axis_tdata[i*W +: W] = r_res4[i];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_s_axis_tvalid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // stage 1: determinant squares a, so b is replaced by a here
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_s_axis_tvalid) begin
            r_mode1 <= su2q_pkg::t_mode'(i_s_axis_tuser);
            for (int i = 0; i < 4; i++) begin
                r_a1[i] <= i_s_axis_tdata[i*W +: W];
                if (su2q_pkg::t_mode'(i_s_axis_tuser) == su2q_pkg::MODE_DET) begin
                    r_b1[i] <= i_s_axis_tdata[i*W +: W];
                end else begin
                    r_b1[i] <= i_s_axis_tdata[(4+i)*W +: W];
                end
            end
        end
    end

    // stage 2: all products, arithmetic shift rounds toward minus infinity
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_prod2[i][j] = (PW'(r_a1[i]) * PW'(r_b1[j])) >>> FRAC_BITS;
            end
        end
        for (int i = 0; i < 4; i++) begin
            case (r_mode1)
                su2q_pkg::MODE_SUM:  n_lin2[i] = LIN_W'(r_a1[i]) + LIN_W'(r_b1[i]);
                su2q_pkg::MODE_DIFF: n_lin2[i] = LIN_W'(r_a1[i]) - LIN_W'(r_b1[i]);
                su2q_pkg::MODE_DAGGER: begin
                    n_lin2[i] = (i == 0) ? LIN_W'(r_a1[i]) : -LIN_W'(r_a1[i]);
                end
                su2q_pkg::MODE_TRACE: begin
                    n_lin2[i] = (i == 0) ? LIN_W'(r_a1[0]) + LIN_W'(r_a1[0]) : '0;
                end
                default: n_lin2[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_mode2 <= r_mode1;
            r_prod2 <= n_prod2;
            r_lin2  <= n_lin2;
        end
    end

    // stage 3: quaternion sums and mode selection
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_acc3[i] = ACC_W'(r_lin2[i]);
        end
        case (r_mode2)
            su2q_pkg::MODE_PRODUCT: begin
                n_acc3[0] = ACC_W'(r_prod2[0][0]) - ACC_W'(r_prod2[1][1])
                          - ACC_W'(r_prod2[2][2]) - ACC_W'(r_prod2[3][3]);
                n_acc3[1] = ACC_W'(r_prod2[0][1]) + ACC_W'(r_prod2[1][0])
                          + ACC_W'(r_prod2[3][2]) - ACC_W'(r_prod2[2][3]);
                n_acc3[2] = ACC_W'(r_prod2[0][2]) + ACC_W'(r_prod2[2][0])
                          + ACC_W'(r_prod2[1][3]) - ACC_W'(r_prod2[3][1]);
                n_acc3[3] = ACC_W'(r_prod2[0][3]) + ACC_W'(r_prod2[3][0])
                          + ACC_W'(r_prod2[2][1]) - ACC_W'(r_prod2[1][2]);
            end
            su2q_pkg::MODE_DET: begin
                n_acc3[0] = ACC_W'(r_prod2[0][0]) + ACC_W'(r_prod2[1][1])
                          + ACC_W'(r_prod2[2][2]) + ACC_W'(r_prod2[3][3]);
                n_acc3[1] = '0;
                n_acc3[2] = '0;
                n_acc3[3] = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_acc3 <= n_acc3;
        end
    end

    // stage 4: saturate to the field range
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_acc3[i] > MAX_V) begin
                n_res4[i] = MAX_V[W-1:0];
            end else if (r_acc3[i] < MIN_V) begin
                n_res4[i] = MIN_V[W-1:0];
            end else begin
                n_res4[i] = r_acc3[i][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r_v3) begin
            r_res4 <= n_res4;
        end
    end

endmodule

[design/su2q_checker.sv]
// port-level checks of the su2 quaternion unit, bound to the top level
`timescale 1ns / 1ps

module su2q_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_s_axis_tvalid,
    input logic                                   o_s_axis_tready,
    input logic                                   o_m_axis_tvalid,
    input logic                                   i_m_axis_tready,
    input logic [((4*DATA_WIDTH+7)/8)*8-1:0]      o_m_axis_tdata
);

    logic       w_in_acc, w_out_acc;
    logic [2:0] r_in_flight;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // transactions accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight <= '0;
        end else begin
            r_in_flight <= r_in_flight + 3'(w_in_acc) - 3'(w_out_acc);
        end
    end

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed or dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_flight <= 3'(su2q_pkg::PIPE_DEPTH))
        else $error("more transactions in flight than pipeline stages");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_flight == '0 |-> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("result without input or empty unit not ready");

endmodule

bind su2_quaternion_alu su2q_checker #(.DATA_WIDTH(DATA_WIDTH)) u_su2q_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
